FILE: sv/idtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID translation table package
// Shared constants, codes and payload types of the ID translation table.
// ----------------------------------------------------------------------------
package idtt_pkg;

   localparam int MAX_IDS      = 1024;
   localparam int IDX_W        = $clog2(MAX_IDS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int OFFSET_FIRST = 1;
   localparam int OFFSET_LIMIT = 999;
   localparam int PROBES       = OFFSET_LIMIT - OFFSET_FIRST;
   localparam int OFF_W        = 10;
   localparam int ID_W         = 23;
   localparam int REG_W        = 22;

   localparam logic [2:0] CMD_SET      = 3'd0;
   localparam logic [2:0] CMD_ERASE    = 3'd1;
   localparam logic [2:0] CMD_TO_REAL  = 3'd2;
   localparam logic [2:0] CMD_TO_VIRT  = 3'd3;
   localparam logic [2:0] CMD_ALLOC    = 3'd4;
   localparam logic [2:0] CMD_CLEAR    = 3'd5;
   localparam logic [2:0] CMD_FORK     = 3'd6;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_NOID  = 2'd2;

   localparam logic REG_BASE_ID   = 1'b0;
   localparam logic REG_SELF_REAL = 1'b1;

   typedef struct packed {
      logic [2:0]        cmd;
      logic signed [23:0] key;
      logic [22:0]       value;
   } req_type;

   typedef struct packed {
      logic signed [23:0] result_id;
      logic              found;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] key;
      logic [ID_W-1:0] real_id;
   } entry_type;

   typedef struct packed {
      logic key_hit;
      logic free;
      logic better;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_PROBE, ST_SCAN, ST_CLEAR, ST_WRITE, ST_RESP
   } state_type;

endpackage

FILE: sv/id_translation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID translation table
// Bidirectional virtual-to-real ID table with a scanning sequencer.
// ----------------------------------------------------------------------------
// A request carries cmd, key and value on req_data and is taken when req_valid
// is high and req_stall is low. Each request gives exactly one response on
// rsp_data, taken when rsp_valid is high and rsp_stall is low.
// The csr port writes base_id (index 0) and self_real_id (index 1); the user is
// to write it only while the block is idle; the block does not enforce this.
// Every scanning command walks the entry memory through its single read port,
// one entry per cycle. Set, erase and fork add a write step when the scan
// finds an entry to write. Clear-and-seed sweeps the memory once and then
// writes the seed entry. Allocate scans the table once per probed ID, up to
// 998 probes.
// After reset the block clears every entry of the memory and holds
// req_stall high meanwhile; configuration writes are taken as usual.
// A finished response sits in the output register; while the receiver stalls
// it holds, and the next finished response waits in the sequencer.
// ----------------------------------------------------------------------------
module id_translation_table
   import idtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [2:0]      cmd_ff, cmd_in;
   logic signed [23:0] key_ff, key_in;
   logic [ID_W-1:0] val_ff, val_in;
   logic [ID_W-1:0] probe_ff, probe_in;
   logic            hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [ID_W-1:0] hit_real_ff, hit_real_in;
   logic            free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic            best_ff, best_in;
   logic [ID_W-1:0] best_key_ff, best_key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [OFF_W-1:0] next_off_ff, next_off_in;
   logic [OFF_W-1:0] probes_ff, probes_in;
   rsp_type         res_ff, res_in;
   logic [IDX_W-1:0] wr_addr_ff, wr_addr_in;
   entry_type       wr_data_ff, wr_data_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [REG_W-1:0] base_ff, self_ff;

   logic            mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type       mem_wr_data;
   entry_type       rd_data;
   cmp_type         cmp;
   logic            scan_done;
   logic            last_sweep;
   logic            out_free;
   logic            accept;
   logic signed [23:0] key_mag;
   logic            key_special;

   idtt_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (scan_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   idtt_cmp u_cmp (
      .entry      (rd_data),
      .probe_key  (probe_ff),
      .probe_val  (val_ff),
      .best_valid (best_ff),
      .best_key   (best_key_ff),
      .result     (cmp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = (state_ff == ST_SCAN) && (scan_cnt_ff == CNT_W'(MAX_IDS)) &&
                       !rd_valid_ff;
   assign last_sweep = (scan_cnt_ff == CNT_W'(MAX_IDS - 1));
   assign key_mag    = req_data.key[23] ? -req_data.key : req_data.key;
   // Keys zero and minus one pass through, and the most negative key has no
   // storable magnitude, so none of them needs a scan.
   assign key_special = (req_data.key == 24'sd0) || (req_data.key == -24'sd1) ||
                        (req_data.key == 24'sh800000);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (last_sweep) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_SET, CMD_ERASE: begin
                     state_in = req_data.key[23] ? ST_RESP : ST_SCAN;
                  end
                  CMD_TO_REAL: begin
                     state_in = key_special ? ST_RESP : ST_SCAN;
                  end
                  CMD_TO_VIRT: begin
                     state_in = (req_data.value == '0) ? ST_RESP : ST_SCAN;
                  end
                  CMD_ALLOC: begin
                     state_in = (32'(count_ff) >= OFFSET_LIMIT) ? ST_RESP : ST_PROBE;
                  end
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_FORK:  state_in = ST_SCAN;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_PROBE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               case (cmd_ff)
                  CMD_SET, CMD_FORK: state_in = (hit_ff || free_ff) ? ST_WRITE : ST_RESP;
                  CMD_ERASE:         state_in = hit_ff ? ST_WRITE : ST_RESP;
                  CMD_ALLOC: begin
                     state_in = (hit_ff && probes_ff != OFF_W'(PROBES - 1)) ?
                                ST_PROBE : ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            if (last_sweep) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = scan_cnt_ff[IDX_W-1:0];
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      probe_in    = probe_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_real_in = hit_real_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      count_in    = count_ff;
      next_off_in = next_off_ff;
      probes_in   = probes_ff;
      res_in      = res_ff;
      wr_addr_in  = wr_addr_ff;
      wr_data_in  = wr_data_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = wr_data_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_cnt_ff[IDX_W-1:0];
            mem_wr_data = '0;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (state_ff == ST_CLEAR && last_sweep) begin
               count_in   = CNT_W'(1);
               wr_addr_in = '0;
               wr_data_in = '{valid: 1'b1, key: {1'b0, base_ff}, real_id: {1'b0, self_ff}};
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_data.cmd;
               key_in      = req_data.key;
               val_in      = req_data.value;
               probe_in    = req_data.key[ID_W-1:0];
               scan_cnt_in = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               best_in     = 1'b0;
               probes_in   = '0;
               res_in      = '{result_id: 24'sd0, found: 1'b0, status: STATUS_OK};
               case (req_data.cmd)
                  CMD_TO_REAL: begin
                     probe_in         = key_mag[ID_W-1:0];
                     res_in.result_id = req_data.key;
                  end
                  CMD_TO_VIRT: res_in.result_id = signed'({1'b0, req_data.value});
                  CMD_ALLOC: begin
                     res_in.result_id = -24'sd1;
                     res_in.status    = STATUS_FULL;
                  end
                  CMD_FORK: begin
                     next_off_in = OFF_W'(OFFSET_FIRST);
                     probe_in    = {1'b0, base_ff};
                     val_in      = {1'b0, self_ff};
                  end
                  default: ;
               endcase
            end
         end
         ST_PROBE: begin
            probe_in    = ID_W'({1'b0, base_ff} + ID_W'(next_off_ff));
            next_off_in = (next_off_ff == OFF_W'(OFFSET_LIMIT - 1)) ?
                          OFF_W'(OFFSET_FIRST) : next_off_ff + 1'b1;
            scan_cnt_in = '0;
            hit_in      = 1'b0;
         end
         ST_SCAN: begin
            if (scan_cnt_ff != CNT_W'(MAX_IDS)) begin
               rd_valid_in = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (cmp.key_hit && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_real_in = rd_data.real_id;
               end
               if (cmp.free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (cmp.better) begin
                  best_in     = 1'b1;
                  best_key_in = rd_data.key;
               end
            end
            if (scan_done) begin
               case (cmd_ff)
                  CMD_SET, CMD_FORK: begin
                     wr_data_in = '{valid: 1'b1, key: probe_ff, real_id: val_ff};
                     if (hit_ff) begin
                        wr_addr_in   = hit_idx_ff;
                        res_in.found = 1'b1;
                     end else if (free_ff) begin
                        wr_addr_in = free_idx_ff;
                        count_in   = count_ff + 1'b1;
                     end else begin
                        res_in.status = STATUS_FULL;
                     end
                  end
                  CMD_ERASE: begin
                     wr_addr_in = hit_idx_ff;
                     wr_data_in = '{valid: 1'b0, key: probe_ff, real_id: val_ff};
                     if (hit_ff) begin
                        count_in     = count_ff - 1'b1;
                        res_in.found = 1'b1;
                     end
                  end
                  CMD_TO_REAL: begin
                     if (hit_ff) begin
                        res_in.found     = 1'b1;
                        res_in.result_id = key_ff[23] ? -signed'({1'b0, hit_real_ff}) :
                                           signed'({1'b0, hit_real_ff});
                     end
                  end
                  CMD_TO_VIRT: begin
                     if (best_ff) begin
                        res_in.found     = 1'b1;
                        res_in.result_id = signed'({1'b0, best_key_ff});
                     end
                  end
                  CMD_ALLOC: begin
                     if (!hit_ff) begin
                        res_in.result_id = signed'({1'b0, probe_ff});
                        res_in.status    = STATUS_OK;
                     end else if (probes_ff == OFF_W'(PROBES - 1)) begin
                        res_in.status = STATUS_NOID;
                     end else begin
                        probes_in = probes_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WRITE: mem_wr_en = 1'b1;
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         scan_cnt_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         next_off_ff  <= OFF_W'(OFFSET_FIRST);
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         self_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         next_off_ff  <= next_off_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == REG_BASE_ID) begin
            base_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == REG_SELF_REAL) begin
            self_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      probe_ff    <= probe_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_real_ff <= hit_real_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      probes_ff   <= probes_in;
      res_ff      <= res_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      rsp_ff      <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_IDS)
      else $error("entry count above table size");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      next_off_ff != '0 && 32'(next_off_ff) < OFFSET_LIMIT)
      else $error("allocation offset out of range");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && out_free |=> rsp_valid_ff)
      else $error("finished response not loaded");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !mem_wr_en)
      else $error("memory written during a scan");

endmodule

FILE: sv/idtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID translation table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module idtt_ram
   import idtt_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_IDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/idtt_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID translation table compare unit
// Matches one read entry against the probe key, the probe value and the best
// key found so far.
// ----------------------------------------------------------------------------
module idtt_cmp
   import idtt_pkg::*;
(
   input  entry_type       entry,
   input  logic [ID_W-1:0] probe_key,
   input  logic [ID_W-1:0] probe_val,
   input  logic            best_valid,
   input  logic [ID_W-1:0] best_key,
   output cmp_type         result
);

   always_comb begin
      result.key_hit = entry.valid && (entry.key == probe_key);
      result.free    = !entry.valid;
      result.better  = entry.valid && (entry.real_id == probe_val) &&
                       (!best_valid || (entry.key < best_key));
   end

endmodule

FILE: tb/id_translation_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID translation table testbench
// Drives a table of directed requests and then constrained random requests
// through the ID translation table. A model of the table built into the bench
// predicts every response. Each response is compared field by field with the
// oldest prediction. The sender and the receiver idle at random, and the
// receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module id_translation_table_test;
   import idtt_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 6;
   localparam int ITEMS_PER_PASS = 180;
   // Longer than a clear-and-seed, so that its response is still held when
   // the next request is taken and the block backs up.
   localparam int HOLD_CYCLES    = 1500;
   localparam int DRAIN_CYCLES   = 16;
   // Each scan walks the whole table. Allocation may probe once for
   // every key that the random part puts near base_id, so allow plenty.
   localparam int STUCK_LIMIT    = 400000;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = REG_BASE_ID;
   logic [REG_W-1:0] csr_wdata = '0;

   id_translation_table dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the table. Slot order is kept as the block keeps it, although
   // only the contents can be seen from outside.
   // ------------------------------------------------------------------------
   logic [ID_W-1:0]  model_key  [MAX_IDS];
   logic [ID_W-1:0]  model_real [MAX_IDS];
   bit               model_used [MAX_IDS];
   int               model_count = 0;
   int               model_offset = OFFSET_FIRST;
   logic [REG_W-1:0] model_base = '0;
   logic [REG_W-1:0] model_self = '0;

   function automatic int slot_of(logic [ID_W-1:0] k);
      for (int i = 0; i < MAX_IDS; i++)
         if (model_used[i] && model_key[i] == k) return i;
      return -1;
   endfunction

   // Overwrites an existing key, or takes the lowest free slot.
   function automatic void map_store(input logic [ID_W-1:0] k, input logic [ID_W-1:0] r,
                                     output logic hit, output logic [1:0] status);
      int i;
      i = slot_of(k);
      hit = 1'b0;
      status = STATUS_OK;
      if (i >= 0) begin
         model_real[i] = r;
         hit = 1'b1;
         return;
      end
      for (int j = 0; j < MAX_IDS; j++) begin
         if (!model_used[j]) begin
            model_key[j] = k;
            model_real[j] = r;
            model_used[j] = 1'b1;
            model_count++;
            return;
         end
      end
      status = STATUS_FULL;
   endfunction

   function automatic rsp_type translate(req_type r);
      rsp_type   o;
      int        k, mag, res, i, cand;
      logic      hit;
      logic [1:0] st;
      logic [ID_W-1:0] best;
      k = r.key;
      res = 0;
      hit = 1'b0;
      st = STATUS_OK;
      best = '0;
      case (r.cmd)
         CMD_SET: begin
            if (k >= 0) map_store(k[ID_W-1:0], r.value, hit, st);
         end
         CMD_ERASE: begin
            if (k >= 0) begin
               i = slot_of(k[ID_W-1:0]);
               if (i >= 0) begin
                  model_used[i] = 1'b0;
                  model_count--;
                  hit = 1'b1;
               end
            end
         end
         CMD_TO_REAL: begin
            res = k;
            if (k > 0 || k < -1) begin
               mag = (k < 0) ? -k : k;
               if (mag < (1 << ID_W)) begin
                  i = slot_of(mag[ID_W-1:0]);
                  if (i >= 0) begin
                     res = (k < 0) ? -int'(model_real[i]) : int'(model_real[i]);
                     hit = 1'b1;
                  end
               end
            end
         end
         CMD_TO_VIRT: begin
            res = r.value;
            if (r.value != 0) begin
               for (int j = 0; j < MAX_IDS; j++)
                  if (model_used[j] && model_real[j] == r.value &&
                      (!hit || model_key[j] < best)) begin
                     best = model_key[j];
                     hit = 1'b1;
                  end
               if (hit) res = best;
            end
         end
         CMD_ALLOC: begin
            res = -1;
            if (model_count >= OFFSET_LIMIT) begin
               st = STATUS_FULL;
            end else begin
               st = STATUS_NOID;
               for (int n = 0; n < PROBES; n++) begin
                  cand = int'(model_base) + model_offset;
                  model_offset++;
                  if (model_offset >= OFFSET_LIMIT) model_offset = OFFSET_FIRST;
                  if (slot_of(cand[ID_W-1:0]) < 0) begin
                     res = cand;
                     st = STATUS_OK;
                     break;
                  end
               end
            end
         end
         CMD_CLEAR: begin
            for (int j = 0; j < MAX_IDS; j++) model_used[j] = 1'b0;
            model_count = 0;
            map_store(model_base, model_self, hit, st);
            hit = 1'b0;
         end
         CMD_FORK: begin
            model_offset = OFFSET_FIRST;
            map_store(model_base, model_self, hit, st);
         end
         default: ;
      endcase
      o.result_id = res[23:0];
      o.found = hit;
      o.status = st;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Prediction at request acceptance and checking at response acceptance.
   // A directed row may carry its own typed answer, which then replaces the
   // model's answer in the queue, although the model still updates its state.
   // ------------------------------------------------------------------------
   rsp_type pending_rsp[$];
   bit      typed_flag[$];
   rsp_type typed_rsp[$];
   int      sent_count = 0;
   int      got_count = 0;
   int      stuck_cycles = 0;
   bit      failed = 1'b0;

   always @(posedge clock) begin
      rsp_type p, exp_r;
      bit      use_typed;
      if (!reset && req_valid && !req_stall) begin
         p = translate(req_data);
         use_typed = typed_flag.pop_front();
         exp_r = typed_rsp.pop_front();
         pending_rsp = {pending_rsp, (use_typed ? exp_r : p)};
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count++;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: %p", rsp_data);
            failed = 1'b1;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_data.result_id !== exp_r.result_id) begin
               $error("result_id expected %0d actual %0d", exp_r.result_id, rsp_data.result_id);
               failed = 1'b1;
            end
            if (rsp_data.found !== exp_r.found) begin
               $error("found expected %0b actual %0b", exp_r.found, rsp_data.found);
               failed = 1'b1;
            end
            if (rsp_data.status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_data.status);
               failed = 1'b1;
            end
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else if (!reset) begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. It stalls at random, and once holds off for a long stretch so
   // that the block fills up and stalls its own input.
   // ------------------------------------------------------------------------
   int recv_idle_pct = 0;
   int send_idle_pct = 0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;

   always @(posedge clock) begin
      static int hold_left = 0;
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------------
   task automatic send_request(req_type r, bit has_typed, rsp_type typed);
      typed_flag = {typed_flag, has_typed};
      typed_rsp = {typed_rsp, typed};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic write_reg(logic idx, logic [REG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_BASE_ID) model_base = data;
      else model_self = data;
   endtask

   // Every request gives a response, so the block is idle once the counts agree.
   task automatic drain();
      req_valid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Keys are kept mostly small, or close above base_id so that allocation
   // has to skip taken ids. A few requests use the whole width of each field.
   function automatic req_type random_request();
      req_type r;
      int      pick, k;
      pick = $urandom_range(99);
      if (pick < 30)      r.cmd = CMD_SET;
      else if (pick < 42) r.cmd = CMD_ERASE;
      else if (pick < 64) r.cmd = CMD_TO_REAL;
      else if (pick < 80) r.cmd = CMD_TO_VIRT;
      else if (pick < 90) r.cmd = CMD_ALLOC;
      else if (pick < 94) r.cmd = CMD_CLEAR;
      else if (pick < 98) r.cmd = CMD_FORK;
      else                r.cmd = CMD_UNUSED;
      pick = $urandom_range(99);
      if (pick < 55)      k = $urandom_range(63);
      else if (pick < 85) k = int'(model_base) + $urandom_range(1, 12);
      else                k = $urandom;
      if ($urandom_range(99) < 20) k = -k;
      r.key = k[23:0];
      r.value = ($urandom_range(99) < 70) ? 23'($urandom_range(15)) : 23'($urandom);
      return r;
   endfunction

   typedef struct {
      req_type r;
      bit      has_typed;
      rsp_type typed;
   } row_type;

   function automatic row_type row(logic [2:0] c, int k, int v, bit t = 0, int res = 0,
                                   logic f = 0, logic [1:0] s = STATUS_OK);
      row_type x;
      x.r.cmd = c;
      x.r.key = k[23:0];
      x.r.value = v[22:0];
      x.has_typed = t;
      x.typed.result_id = res[23:0];
      x.typed.found = f;
      x.typed.status = s;
      return x;
   endfunction

   row_type directed[$];

   initial begin
      row_type one_row;
      // Right after reset the table is empty with base_id and self_real_id 0.
      directed = '{
         row(CMD_TO_REAL, 0, 0, 1, 0),
         row(CMD_TO_REAL, -1, 0, 1, -1),
         row(CMD_TO_VIRT, 0, 0, 1, 0),
         row(CMD_TO_REAL, 8388607, 0, 1, 8388607),
         row(CMD_TO_REAL, -8388608, 0, 1, -8388608),
         row(CMD_TO_VIRT, 0, 8388607, 1, 8388607),
         row(CMD_SET, -5, 9, 1, 0),
         row(CMD_ERASE, -5, 0, 1, 0),
         row(CMD_UNUSED, 8388607, 8388607, 1, 0),
         row(CMD_SET, 5, 100),
         row(CMD_SET, 5, 200),
         row(CMD_TO_REAL, 5, 0),
         row(CMD_TO_REAL, -5, 0),
         row(CMD_SET, 8388607, 8388607),
         row(CMD_TO_REAL, 8388607, 0),
         row(CMD_TO_VIRT, 0, 8388607),
         row(CMD_SET, 3, 200),
         row(CMD_TO_VIRT, 0, 200),
         row(CMD_ERASE, 5, 0),
         row(CMD_ERASE, 5, 0),
         row(CMD_ALLOC, 0, 0),
         row(CMD_ALLOC, 0, 0),
         row(CMD_FORK, 0, 0),
         row(CMD_CLEAR, 0, 0),
         row(CMD_ALLOC, 0, 0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The registers may be written during the clearing pass after reset.
      write_reg(REG_BASE_ID, '0);
      write_reg(REG_SELF_REAL, '0);

      send_idle_pct = 10;
      recv_idle_pct = 54;
      foreach (directed[i]) send_request(directed[i].r, directed[i].has_typed, directed[i].typed);

      for (int pass = 0; pass < 3; pass++) begin
         drain();
         case (pass)
            0: begin
               write_reg(REG_BASE_ID, '1);
               write_reg(REG_SELF_REAL, '1);
            end
            1: begin
               write_reg(REG_BASE_ID, REG_W'($urandom));
               write_reg(REG_SELF_REAL, REG_W'($urandom));
               send_idle_pct = 54;
               recv_idle_pct = 10;
            end
            default: begin
               write_reg(REG_BASE_ID, '0);
               write_reg(REG_SELF_REAL, '1);
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // Seed the table with the new registers so that the passes differ.
         one_row = row(CMD_CLEAR, 0, 0);
         send_request(one_row.r, 1'b0, '0);
         if (pass == 2) begin
            // Cheap requests offered during a long hold-off back the block up.
            hold_request = 1'b1;
            one_row = row(CMD_TO_REAL, 0, 0);
            repeat (12) send_request(one_row.r, 1'b0, '0);
         end
         repeat (ITEMS_PER_PASS) send_request(random_request(), 1'b0, '0);
      end

      drain();
      if (!failed && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/idtt_pkg.sv
sv/idtt_ram.sv
sv/idtt_cmp.sv
sv/id_translation_table.sv
tb/id_translation_table_test.sv
